// File: design/sparse_coordinate_matrix_store_assert.svh
// assertion macros for the sparse coordinate matrix store
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef SPARSE_COORDINATE_MATRIX_STORE_ASSERT_SVH
`define SPARSE_COORDINATE_MATRIX_STORE_ASSERT_SVH

// same-cycle implication
`define SCMS_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("scms assertion failed");

// next-cycle implication
`define SCMS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("scms assertion failed");

`endif

// File: design/scms_pkg.sv
// shared types, constants and helpers of the sparse coordinate matrix store
// no dependencies
`timescale 1ns / 1ps

package scms_pkg;

  localparam int MAX_DIM    = 8;
  localparam int CAPACITY   = 64;
  localparam int VALUE_BITS = 16;
  localparam int RES_LIMIT  = 8;

  localparam int MODE_W   = 3;
  localparam int DIM_W    = 3;
  localparam int DIMREG_W = 4;
  localparam int CNT_W    = 7;
  localparam int ADDR_W   = 6;
  localparam int RES_W    = 4;
  localparam int ENTRY_W  = VALUE_BITS + 2 * DIM_W;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD     = 3'd0,
    MODE_GET_ELEM = 3'd1,
    MODE_GET_ROW  = 3'd2,
    MODE_GET_COL  = 3'd3,
    MODE_CLEAR    = 3'd4
  } mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_CLEAR,
    ST_SCAN,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic capture;
    logic do_load;
    logic do_clear;
    logic scan_en;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
    logic scan_done;
  } dp_status_t;

  // dimension register clamped to 1..MAX_DIM
  function automatic logic [DIMREG_W-1:0] eff_dim(input logic [DIMREG_W-1:0] r);
    logic [DIMREG_W-1:0] d;
    if (r == '0) begin
      d = DIMREG_W'(1);
    end else if (r > DIMREG_W'(MAX_DIM)) begin
      d = DIMREG_W'(MAX_DIM);
    end else begin
      d = r;
    end
    return d;
  endfunction

endpackage

// File: design/scms_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module scms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/scms_ctrl.sv
// controller state machine of the sparse coordinate matrix store
// depends on scms_pkg
`timescale 1ns / 1ps

module scms_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic [scms_pkg::MODE_W-1:0] mode_i,
  input  scms_pkg::dp_status_t        status_i,
  output logic                        in_ready_o,
  output scms_pkg::ctrl_cmd_t         cmd_o
);

  import scms_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          if (mode_i == MODE_LOAD) begin
            state_d = ST_LOAD;
          end else if (mode_i inside {MODE_GET_ELEM, MODE_GET_ROW, MODE_GET_COL}) begin
            state_d = ST_SCAN;
          end else if (mode_i == MODE_CLEAR) begin
            state_d = ST_CLEAR;
          end
        end
      end
      ST_LOAD: begin
        if (status_i.out_free) begin
          cmd_o.do_load = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      ST_CLEAR: begin
        if (status_i.out_free) begin
          cmd_o.do_clear = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      ST_SCAN: begin
        cmd_o.scan_en = 1'b1;
        if (status_i.scan_done) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// File: design/scms_dp.sv
// datapath of the sparse coordinate matrix store: entry ram, load position,
// scan counters, pending match and output register; depends on scms_pkg, scms_ram
`timescale 1ns / 1ps

module scms_dp (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  scms_pkg::ctrl_cmd_t                   cmd_i,
  output scms_pkg::dp_status_t                  status_o,
  input  logic [scms_pkg::MODE_W-1:0]           mode_i,
  input  logic signed [scms_pkg::VALUE_BITS-1:0] value_i,
  input  logic [scms_pkg::DIM_W-1:0]            row_index_i,
  input  logic [scms_pkg::DIM_W-1:0]            col_index_i,
  input  logic [scms_pkg::DIMREG_W-1:0]         num_rows_i,
  input  logic [scms_pkg::DIMREG_W-1:0]         num_cols_i,
  input  logic                                  out_ready_i,
  output logic                                  out_valid_o,
  output logic signed [scms_pkg::VALUE_BITS-1:0] value_res_o,
  output logic [scms_pkg::DIM_W-1:0]            entry_row_o,
  output logic [scms_pkg::DIM_W-1:0]            entry_col_o,
  output logic                                  found_o,
  output logic [scms_pkg::CNT_W-1:0]            entry_total_o,
  output logic                                  load_ignored_o,
  output logic                                  last_o
);

  import scms_pkg::*;

  // captured transaction
  mode_e                  mode_q;
  logic [VALUE_BITS-1:0]  value_q;
  logic [DIM_W-1:0]       qrow_q, qcol_q;

  // matrix state
  logic [CNT_W-1:0] entry_count_q;
  logic [DIM_W-1:0] load_row_q, load_col_q;
  logic             load_done_q;

  // scan state
  logic [CNT_W-1:0]      issue_idx_q;
  logic                  rd_vld_q;
  logic [RES_W-1:0]      n_q, n_d;
  logic                  pend_vld_q;
  logic [ENTRY_W-1:0]    pend_q;
  logic                  hit_q;
  logic [VALUE_BITS-1:0] hit_val_q;

  // output register
  logic                  out_vld_q;
  logic [VALUE_BITS-1:0] out_value_q;
  logic [DIM_W-1:0]      out_row_q, out_col_q;
  logic                  out_found_q, out_ign_q, out_last_q;
  logic [CNT_W-1:0]      out_total_q;

  logic                  out_free;
  logic [ENTRY_W-1:0]    rdata;
  logic [VALUE_BITS-1:0] rd_value, pend_value;
  logic [DIM_W-1:0]      rd_row, rd_col, pend_row, pend_col;
  logic                  sel_hit, match, is_elem, need_push, stall, step, take_list;
  logic                  issue_more, rd_en;

  logic [DIMREG_W-1:0] rows, cols;
  logic                load_skip, col_wrap, row_end, val_zero, full, store;

  logic                  push;
  logic [VALUE_BITS-1:0] res_value;
  logic [DIM_W-1:0]      res_row, res_col;
  logic                  res_found, res_ign, res_last;
  logic [CNT_W-1:0]      res_total;

  assign out_free = !out_vld_q || out_ready_i;

  // ---------------- entry ram
  assign rd_value   = rdata[ENTRY_W-1 -: VALUE_BITS];
  assign rd_row     = rdata[2*DIM_W-1 -: DIM_W];
  assign rd_col     = rdata[DIM_W-1:0];
  assign pend_value = pend_q[ENTRY_W-1 -: VALUE_BITS];
  assign pend_row   = pend_q[2*DIM_W-1 -: DIM_W];
  assign pend_col   = pend_q[DIM_W-1:0];

  scms_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (store),
    .waddr_i (entry_count_q[ADDR_W-1:0]),
    .wdata_i ({value_q, load_row_q, load_col_q}),
    .re_i    (rd_en),
    .raddr_i (issue_idx_q[ADDR_W-1:0]),
    .rdata_o (rdata)
  );

  // ---------------- scan
  always_comb begin
    case (mode_q)
      MODE_GET_ELEM: sel_hit = (rd_row == qrow_q) && (rd_col == qcol_q);
      MODE_GET_ROW:  sel_hit = (rd_row == qrow_q);
      MODE_GET_COL:  sel_hit = (rd_col == qcol_q);
      default:       sel_hit = 1'b0;
    endcase
  end

  assign is_elem   = (mode_q == MODE_GET_ELEM);
  assign match     = cmd_i.scan_en && rd_vld_q && sel_hit;
  // a new row or column match sends the previous one out
  assign need_push = match && !is_elem && pend_vld_q;
  assign stall     = need_push && !out_free;
  assign step      = cmd_i.scan_en && !stall;
  assign take_list = step && match && !is_elem;
  assign n_d       = n_q + RES_W'(take_list);
  assign issue_more = (issue_idx_q < entry_count_q) && (n_d != RES_W'(RES_LIMIT));
  assign rd_en     = step && issue_more;

  assign status_o.out_free  = out_free;
  assign status_o.scan_done = !rd_vld_q &&
                              !((issue_idx_q < entry_count_q) && (n_q != RES_W'(RES_LIMIT)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issue_idx_q <= '0;
      rd_vld_q    <= 1'b0;
      n_q         <= '0;
      pend_vld_q  <= 1'b0;
      hit_q       <= 1'b0;
    end else if (cmd_i.capture) begin
      issue_idx_q <= '0;
      rd_vld_q    <= 1'b0;
      n_q         <= '0;
      pend_vld_q  <= 1'b0;
      hit_q       <= 1'b0;
    end else if (step) begin
      issue_idx_q <= issue_idx_q + CNT_W'(rd_en);
      rd_vld_q    <= rd_en;
      n_q         <= n_d;
      if (take_list) begin
        pend_vld_q <= 1'b1;
      end
      if (match && is_elem) begin
        hit_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mode_q  <= mode_e'(mode_i);
      value_q <= value_i;
      qrow_q  <= row_index_i;
      qcol_q  <= col_index_i;
    end
    if (take_list) begin
      pend_q <= rdata;
    end
    if (step && match && is_elem) begin
      hit_val_q <= rd_value;
    end
  end

  // ---------------- load
  assign rows      = eff_dim(num_rows_i);
  assign cols      = eff_dim(num_cols_i);
  assign load_skip = load_done_q || ({1'b0, load_row_q} >= rows);
  assign col_wrap  = ({1'b0, load_col_q} + DIMREG_W'(1)) >= cols;
  assign row_end   = ({1'b0, load_row_q} + DIMREG_W'(1)) >= rows;
  assign val_zero  = (value_q == '0);
  assign full      = (entry_count_q >= CNT_W'(CAPACITY));
  assign store     = cmd_i.do_load && !load_skip && !val_zero && !full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count_q <= '0;
      load_row_q    <= '0;
      load_col_q    <= '0;
      load_done_q   <= 1'b0;
    end else if (cmd_i.do_clear) begin
      entry_count_q <= '0;
      load_row_q    <= '0;
      load_col_q    <= '0;
      load_done_q   <= 1'b0;
    end else if (cmd_i.do_load) begin
      if (load_skip) begin
        load_done_q <= 1'b1;
      end else begin
        if (col_wrap) begin
          load_col_q <= '0;
          if (row_end) begin
            load_done_q <= 1'b1;
          end else begin
            load_row_q <= load_row_q + DIM_W'(1);
          end
        end else begin
          load_col_q <= load_col_q + DIM_W'(1);
        end
      end
      if (store) begin
        entry_count_q <= entry_count_q + CNT_W'(1);
      end
    end
  end

  // ---------------- result selection
  always_comb begin
    push      = 1'b0;
    res_value = '0;
    res_row   = '0;
    res_col   = '0;
    res_found = 1'b0;
    res_ign   = 1'b0;
    res_last  = 1'b1;
    res_total = entry_count_q;
    if (cmd_i.do_load) begin
      push      = 1'b1;
      res_total = entry_count_q + CNT_W'(store);
      if (load_skip) begin
        res_ign = 1'b1;
      end else begin
        res_row = load_row_q;
        res_col = load_col_q;
        if (!val_zero) begin
          if (full) begin
            res_ign = 1'b1;
          end else begin
            res_value = value_q;
            res_found = 1'b1;
          end
        end
      end
    end else if (cmd_i.do_clear) begin
      push      = 1'b1;
      res_total = '0;
    end else if (need_push && step) begin
      push      = 1'b1;
      res_value = pend_value;
      res_row   = pend_row;
      res_col   = pend_col;
      res_found = 1'b1;
      res_last  = 1'b0;
    end else if (cmd_i.finish) begin
      push = 1'b1;
      if (is_elem) begin
        res_value = hit_q ? hit_val_q : '0;
        res_row   = qrow_q;
        res_col   = qcol_q;
        res_found = hit_q;
      end else if (pend_vld_q) begin
        res_value = pend_value;
        res_row   = pend_row;
        res_col   = pend_col;
        res_found = 1'b1;
      end else begin
        res_row = (mode_q == MODE_GET_ROW) ? qrow_q : '0;
        res_col = (mode_q == MODE_GET_COL) ? qcol_q : '0;
      end
    end
  end

  // ---------------- output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (push) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      out_value_q <= res_value;
      out_row_q   <= res_row;
      out_col_q   <= res_col;
      out_found_q <= res_found;
      out_ign_q   <= res_ign;
      out_last_q  <= res_last;
      out_total_q <= res_total;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign value_res_o    = out_value_q;
  assign entry_row_o    = out_row_q;
  assign entry_col_o    = out_col_q;
  assign found_o        = out_found_q;
  assign entry_total_o  = out_total_q;
  assign load_ignored_o = out_ign_q;
  assign last_o         = out_last_q;

endmodule

// File: design/sparse_coordinate_matrix_store.sv
// sparse coordinate matrix store, top level; depends on scms_pkg, scms_ctrl, scms_dp
// load and clear: result registered once the output is free; no new item is taken before that
// queries: one entry ram read per cycle, the scan stops early once 8 row or column matches
// are taken; output stalls pause the scan
// reset: async active low, clears control and counters to an empty store, dimensions to 8;
`timescale 1ns / 1ps
`include "sparse_coordinate_matrix_store_assert.svh"

// the entry ram is not cleared, the entry count alone marks which entries are live
module sparse_coordinate_matrix_store (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // input channel
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic [scms_pkg::MODE_W-1:0]            mode_i,
  input  logic signed [scms_pkg::VALUE_BITS-1:0] value_i,
  input  logic [scms_pkg::DIM_W-1:0]             row_index_i,
  input  logic [scms_pkg::DIM_W-1:0]             col_index_i,
  // result channel
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic signed [scms_pkg::VALUE_BITS-1:0] value_res_o,
  output logic [scms_pkg::DIM_W-1:0]             entry_row_o,
  output logic [scms_pkg::DIM_W-1:0]             entry_col_o,
  output logic                                   found_o,
  output logic [scms_pkg::CNT_W-1:0]             entry_total_o,
  output logic                                   load_ignored_o,
  output logic                                   last_o,
  // configuration port
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [2:0]                             paddr,
  input  logic [31:0]                            pwdata,
  output logic [31:0]                            prdata,
  output logic                                   pready
);

  import scms_pkg::*;

  // dimension registers: num_rows at 0x0, num_cols at 0x4
  logic [DIMREG_W-1:0] num_rows_q, num_cols_q;
  logic                cfg_write;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_rows_q <= DIMREG_W'(MAX_DIM);
      num_cols_q <= DIMREG_W'(MAX_DIM);
    end else if (cfg_write) begin
      if (paddr[2]) begin
        num_cols_q <= pwdata[DIMREG_W-1:0];
      end else begin
        num_rows_q <= pwdata[DIMREG_W-1:0];
      end
    end
  end

  // read data ignores the byte offset bits
  assign prdata = paddr[2] ? {{(32-DIMREG_W){1'b0}}, num_cols_q}
                           : {{(32-DIMREG_W){1'b0}}, num_rows_q};

  // sequencing: accept, load / clear / scan / final result
  scms_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .mode_i     (mode_i),
    .status_i   (status),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd)
  );

  // storage, scan compare and the result register
  scms_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .mode_i         (mode_i),
    .value_i        (value_i),
    .row_index_i    (row_index_i),
    .col_index_i    (col_index_i),
    .num_rows_i     (num_rows_q),
    .num_cols_i     (num_cols_q),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .value_res_o    (value_res_o),
    .entry_row_o    (entry_row_o),
    .entry_col_o    (entry_col_o),
    .found_o        (found_o),
    .entry_total_o  (entry_total_o),
    .load_ignored_o (load_ignored_o),
    .last_o         (last_o)
  );

  // the entry count never passes the store capacity
  `SCMS_ASSERT_IMPLY(a_total_bound, out_valid_o, entry_total_o <= CNT_W'(CAPACITY))
  // an ignored load never reports a stored entry and stands alone
  `SCMS_ASSERT_IMPLY(a_ignored_clean, out_valid_o && load_ignored_o, !found_o && last_o)
  // only row or column matches produce results before the last one
  `SCMS_ASSERT_IMPLY(a_nonlast_found, out_valid_o && !last_o, found_o)
  // a valid mode keeps the block busy in the cycle after its transaction
  `SCMS_ASSERT_NEXT(a_busy_after_accept,
                    in_valid_i && in_ready_o && (mode_i <= MODE_CLEAR), !in_ready_o)

endmodule

// File: test/tb.sv
// self-checking testbench for sparse_coordinate_matrix_store: random and directed traffic
// on the item and result channels, with a shadow store that predicts every result
// depends on scms_pkg and the design under design/
`timescale 1ns / 1ps

module tb;
  import scms_pkg::*;

  // register indexes of the configuration port
  localparam int REG_NUM_ROWS = 0;
  localparam int REG_NUM_COLS = 1;
  // mode codes the block ignores
  localparam logic [MODE_W-1:0] MODE_RESERVED_LO  = 3'd5;
  localparam logic [MODE_W-1:0] MODE_RESERVED_MID = 3'd6;
  localparam logic [MODE_W-1:0] MODE_RESERVED_HI  = 3'd7;
  // cycles to let a query finish before touching the registers or ending the run
  localparam int SETTLE_CYCLES  = 80;
  // cycles with no transaction of any kind before the run is declared hung
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int TARGET_ITEMS   = 310;
  localparam int MAX_PRINTED    = 100;

  typedef struct {
    logic [MODE_W-1:0]            mode;
    logic signed [VALUE_BITS-1:0] value;
    logic [DIM_W-1:0]             row;
    logic [DIM_W-1:0]             col;
  } matrix_op_t;

  typedef struct {
    logic signed [VALUE_BITS-1:0] value;
    logic [DIM_W-1:0]             row;
    logic [DIM_W-1:0]             col;
    logic                         found;
    logic [CNT_W-1:0]             total;
    logic                         ignored;
    logic                         last;
  } matrix_result_t;

  // dut ports, inputs all known from time zero
  logic                         clk_i          = 1'b0;
  logic                         rst_ni         = 1'b0;
  logic                         in_valid_i     = 1'b0;
  logic                         in_ready_o;
  logic [MODE_W-1:0]            mode_i         = '0;
  logic signed [VALUE_BITS-1:0] value_i        = '0;
  logic [DIM_W-1:0]             row_index_i    = '0;
  logic [DIM_W-1:0]             col_index_i    = '0;
  logic                         out_valid_o;
  logic                         out_ready_i    = 1'b0;
  logic signed [VALUE_BITS-1:0] value_res_o;
  logic [DIM_W-1:0]             entry_row_o;
  logic [DIM_W-1:0]             entry_col_o;
  logic                         found_o;
  logic [CNT_W-1:0]             entry_total_o;
  logic                         load_ignored_o;
  logic                         last_o;
  logic                         psel           = 1'b0;
  logic                         penable        = 1'b0;
  logic                         pwrite         = 1'b0;
  logic [2:0]                   paddr          = '0;
  logic [31:0]                  pwdata         = '0;
  logic [31:0]                  prdata;
  logic                         pready;

  // shadow copy of the store, the load cursor and the dimension registers
  logic signed [VALUE_BITS-1:0] shadow_val [CAPACITY];
  logic [DIM_W-1:0]             shadow_row [CAPACITY];
  logic [DIM_W-1:0]             shadow_col [CAPACITY];
  int                           shadow_count = 0;
  int                           cursor_row   = 0;
  int                           cursor_col   = 0;
  bit                           matrix_full  = 1'b0;
  logic [DIMREG_W-1:0]          cfg_rows     = 4'd8;
  logic [DIMREG_W-1:0]          cfg_cols     = 4'd8;

  matrix_op_t     pending_ops[$];
  matrix_result_t awaited_results[$];
  matrix_op_t     next_op;
  bit             in_fire      = 1'b0;
  bit             calm         = 1'b0;
  int             send_gap     = 0;
  int             ready_hold   = 0;
  int             items_sent   = 0;
  int             mismatches   = 0;
  int             quiet_cycles = 0;

  sparse_coordinate_matrix_store uut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // gap length for either side: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // out-of-range dimension registers act as 1 or as the largest size
  function automatic int clamp_dim(input logic [DIMREG_W-1:0] r);
    if (r == '0) return 1;
    if (r > DIMREG_W'(MAX_DIM)) return MAX_DIM;
    return int'(r);
  endfunction

  function automatic logic signed [VALUE_BITS-1:0] rand_value();
    case ($urandom_range(0, 9))
      0, 1, 2: return '0;
      3:       return 16'sh7fff;
      4:       return 16'sh8000;
      5:       return -16'sd1;
      default: return VALUE_BITS'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [DIMREG_W-1:0] pick_dim();
    case ($urandom_range(0, 9))
      0:       return 4'd0;
      1:       return 4'd15;
      2:       return DIMREG_W'($urandom_range(9, 14));
      3:       return 4'd1;
      4, 5:    return 4'd8;
      default: return DIMREG_W'($urandom_range(2, 7));
    endcase
  endfunction

  // query index, mostly inside the loaded matrix so that queries hit
  function automatic logic [DIM_W-1:0] pick_index(input int dim);
    if ($urandom_range(0, 9) < 7) return DIM_W'($urandom_range(0, dim - 1));
    return DIM_W'($urandom_range(0, 7));
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatches < MAX_PRINTED) $display("mismatch at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  // apply one accepted transaction to the shadow store and queue its results
  task automatic predict_matrix_op(input matrix_op_t op);
    matrix_result_t res;
    int             rows;
    int             cols;
    int             hits;
    int             limit;
    bit             sel;
    res = '{value: '0, row: '0, col: '0, found: 1'b0, total: '0, ignored: 1'b0,
            last: 1'b1};
    case (op.mode)
      MODE_LOAD: begin
        rows = clamp_dim(cfg_rows);
        cols = clamp_dim(cfg_cols);
        if (matrix_full || cursor_row >= rows) begin
          // loads past the end of the matrix, also after the rows shrank under the cursor
          matrix_full = 1'b1;
          res.ignored = 1'b1;
        end else begin
          res.row = DIM_W'(cursor_row);
          res.col = DIM_W'(cursor_col);
          // raster advance; a column beyond a narrowed width wraps after use
          if (cursor_col + 1 >= cols) begin
            cursor_col = 0;
            if (cursor_row + 1 >= rows) matrix_full = 1'b1;
            else cursor_row++;
          end else begin
            cursor_col++;
          end
          if (op.value == '0) begin
            // zero elements take a position but are not stored
          end else if (shadow_count >= CAPACITY) begin
            res.ignored = 1'b1;
          end else begin
            shadow_val[shadow_count] = op.value;
            shadow_row[shadow_count] = res.row;
            shadow_col[shadow_count] = res.col;
            shadow_count++;
            res.value = op.value;
            res.found = 1'b1;
          end
        end
        res.total = CNT_W'(shadow_count);
        awaited_results.push_back(res);
      end
      MODE_GET_ELEM: begin
        // the newest entry at the position wins
        res.row = op.row;
        res.col = op.col;
        for (int i = 0; i < shadow_count; i++) begin
          if (shadow_row[i] == op.row && shadow_col[i] == op.col) begin
            res.found = 1'b1;
            res.value = shadow_val[i];
          end
        end
        res.total = CNT_W'(shadow_count);
        awaited_results.push_back(res);
      end
      MODE_GET_ROW, MODE_GET_COL: begin
        limit = 0;
        for (int i = 0; i < shadow_count; i++) begin
          sel = (op.mode == MODE_GET_ROW) ? shadow_row[i] == op.row : shadow_col[i] == op.col;
          if (sel) limit++;
        end
        if (limit > RES_LIMIT) limit = RES_LIMIT;
        res.total = CNT_W'(shadow_count);
        if (limit == 0) begin
          // no match: one empty result echoing the asked index
          res.row = (op.mode == MODE_GET_ROW) ? op.row : '0;
          res.col = (op.mode == MODE_GET_COL) ? op.col : '0;
          awaited_results.push_back(res);
        end else begin
          hits = 0;
          for (int i = 0; i < shadow_count; i++) begin
            sel = (op.mode == MODE_GET_ROW) ? shadow_row[i] == op.row : shadow_col[i] == op.col;
            if (sel && hits < limit) begin
              res.value = shadow_val[i];
              res.row   = shadow_row[i];
              res.col   = shadow_col[i];
              res.found = 1'b1;
              res.last  = (hits == limit - 1);
              awaited_results.push_back(res);
              hits++;
            end
          end
        end
      end
      MODE_CLEAR: begin
        shadow_count = 0;
        cursor_row   = 0;
        cursor_col   = 0;
        matrix_full  = 1'b0;
        awaited_results.push_back(res);
      end
      default: begin
        // reserved modes leave everything as it is and give no result
      end
    endcase
  endtask

  // monitor: predict on each accepted item, check each accepted result
  always @(posedge clk_i) begin
    matrix_result_t want;
    matrix_op_t     seen;
    in_fire <= rst_ni && in_valid_i && in_ready_o;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        seen = '{mode: mode_i, value: value_i, row: row_index_i, col: col_index_i};
        predict_matrix_op(seen);
      end
      if (out_valid_o && out_ready_i) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("result transaction with nothing expected");
        end else begin
          want = awaited_results.pop_front();
          if (value_res_o !== want.value)
            report_mismatch($sformatf("value_res %0d, expected %0d", value_res_o, want.value));
          if (entry_row_o !== want.row)
            report_mismatch($sformatf("entry_row %0d, expected %0d", entry_row_o, want.row));
          if (entry_col_o !== want.col)
            report_mismatch($sformatf("entry_col %0d, expected %0d", entry_col_o, want.col));
          if (found_o !== want.found)
            report_mismatch($sformatf("found %b, expected %b", found_o, want.found));
          if (entry_total_o !== want.total)
            report_mismatch($sformatf("entry_total %0d, expected %0d", entry_total_o,
                                      want.total));
          if (load_ignored_o !== want.ignored)
            report_mismatch($sformatf("load_ignored %b, expected %b", load_ignored_o,
                                      want.ignored));
          if (last_o !== want.last)
            report_mismatch($sformatf("last %b, expected %b", last_o, want.last));
        end
      end
    end
  end

  // watchdog: any item, result or register write transaction counts as progress
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (psel && penable && pwrite && pready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // item driver: holds each item until taken, then a random gap or the next one
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_fire)) begin
      if (send_gap > 0) begin
        in_valid_i <= 1'b0;
        send_gap--;
      end else if (pending_ops.size() > 0) begin
        next_op = pending_ops.pop_front();
        mode_i      <= next_op.mode;
        value_i     <= next_op.value;
        row_index_i <= next_op.row;
        col_index_i <= next_op.col;
        in_valid_i  <= 1'b1;
        send_gap = pick_gap();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result side back-pressure
  always @(negedge clk_i) begin
    if (ready_hold == 0 && $urandom_range(0, 3) == 0) ready_hold = pick_gap();
    if (ready_hold > 0) begin
      out_ready_i <= 1'b0;
      ready_hold--;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  task automatic queue_op(input logic [MODE_W-1:0] mode, input logic signed [VALUE_BITS-1:0] value,
                          input logic [DIM_W-1:0] row, input logic [DIM_W-1:0] col);
    pending_ops.push_back('{mode: mode, value: value, row: row, col: col});
    if (mode <= MODE_CLEAR) items_sent++;
  endtask

  task automatic queue_load();
    queue_op(MODE_LOAD, rand_value(), DIM_W'($urandom_range(0, 7)),
             DIM_W'($urandom_range(0, 7)));
  endtask

  task automatic queue_query();
    logic [MODE_W-1:0] mode;
    case ($urandom_range(0, 2))
      0:       mode = MODE_GET_ELEM;
      1:       mode = MODE_GET_ROW;
      default: mode = MODE_GET_COL;
    endcase
    queue_op(mode, VALUE_BITS'($urandom_range(0, 65535)), pick_index(clamp_dim(cfg_rows)),
             pick_index(clamp_dim(cfg_cols)));
  endtask

  // loads with queries mixed in
  task automatic queue_loads(input int count);
    repeat (count) begin
      queue_load();
      if ($urandom_range(0, 4) == 0) queue_query();
    end
  endtask

  // sender holds off until every result is back, then the block gets time to go idle
  task automatic wait_idle();
    do @(posedge clk_i);
    while (pending_ops.size() != 0 || in_valid_i || awaited_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // apb write: setup then access, register takes the value on the access edge
  task automatic write_reg(input int index, input logic [DIMREG_W-1:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= 3'(4 * index);
    pwdata  <= 32'(data);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i);
    while (!pready);
    if (index == REG_NUM_ROWS) cfg_rows = data;
    else cfg_cols = data;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_dims(input logic [DIMREG_W-1:0] rows, input logic [DIMREG_W-1:0] cols);
    write_reg(REG_NUM_ROWS, rows);
    write_reg(REG_NUM_COLS, cols);
  endtask

  // one random phase: new size, clear, load the matrix with queries in between
  task automatic run_phase();
    int cells;
    calm = ($urandom_range(0, 4) == 0);
    set_dims(pick_dim(), pick_dim());
    queue_op(MODE_CLEAR, rand_value(), DIM_W'($urandom_range(0, 7)),
             DIM_W'($urandom_range(0, 7)));
    cells = clamp_dim(cfg_rows) * clamp_dim(cfg_cols);
    if ($urandom_range(0, 3) == 0) begin
      // resize with the load half done, cursor stays where it is
      queue_loads((cells + 1) / 2);
      wait_idle();
      set_dims(pick_dim(), pick_dim());
      cells = clamp_dim(cfg_rows) * clamp_dim(cfg_cols);
    end
    queue_loads(cells + $urandom_range(0, 2));
    repeat ($urandom_range(2, 6)) queue_query();
    if ($urandom_range(0, 5) == 0)
      queue_op(MODE_W'($urandom_range(MODE_RESERVED_LO, MODE_RESERVED_HI)), rand_value(),
               DIM_W'($urandom_range(0, 7)), DIM_W'($urandom_range(0, 7)));
    wait_idle();
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // empty store: every query misses and echoes its index
    queue_op(MODE_GET_ELEM, 16'sh0000, 3'd7, 3'd7);
    queue_op(MODE_GET_ROW, 16'sh7fff, 3'd7, 3'd0);
    queue_op(MODE_GET_COL, 16'sh8000, 3'd0, 3'd7);
    // value extremes and a zero along row 0 of the reset 8x8 matrix
    queue_op(MODE_LOAD, 16'sh7fff, 3'd7, 3'd7);
    queue_op(MODE_LOAD, 16'sh8000, 3'd0, 3'd0);
    queue_op(MODE_LOAD, 16'sh0000, 3'd5, 3'd2);
    queue_op(MODE_LOAD, -16'sd1, 3'd2, 3'd5);
    queue_op(MODE_LOAD, 16'sd1, 3'd0, 3'd0);
    queue_op(MODE_GET_ROW, 16'sh0000, 3'd0, 3'd3);
    queue_op(MODE_GET_COL, 16'sh0000, 3'd6, 3'd1);
    queue_op(MODE_GET_ELEM, 16'sh0000, 3'd0, 3'd1);
    queue_op(MODE_GET_ELEM, 16'sh0000, 3'd0, 3'd2);
    // reserved modes do nothing
    queue_op(MODE_RESERVED_LO, 16'sh1234, 3'd1, 3'd1);
    queue_op(MODE_RESERVED_MID, 16'sh0000, 3'd0, 3'd0);
    queue_op(MODE_RESERVED_HI, -16'sd1, 3'd7, 3'd7);
    queue_op(MODE_CLEAR, 16'sh0000, 3'd0, 3'd0);
    wait_idle();

    // 1x2 matrix, then a load past its end
    set_dims(4'd1, 4'd2);
    queue_op(MODE_LOAD, 16'sd5, 3'd0, 3'd0);
    queue_op(MODE_LOAD, 16'sd0, 3'd0, 3'd0);
    queue_op(MODE_LOAD, 16'sd7, 3'd0, 3'd0);
    queue_op(MODE_GET_ROW, 16'sd0, 3'd0, 3'd0);
    wait_idle();

    // zero registers act as a 1x1 matrix
    set_dims(4'd0, 4'd0);
    queue_op(MODE_CLEAR, 16'sd0, 3'd0, 3'd0);
    queue_op(MODE_LOAD, -16'sd5, 3'd0, 3'd0);
    queue_op(MODE_LOAD, 16'sd3, 3'd0, 3'd0);
    wait_idle();

    while (items_sent < TARGET_ITEMS) run_phase();

    if (mismatches == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
